/* hw/rtl/sjt_pkg.sv */
// Shared types and constants for the permutation generator.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package sjt_pkg;

    // Fixed field widths and the default maximum element count
    localparam int ELEM_W           = 4;
    localparam int CNT_W            = 5;
    localparam int ARR_W            = 64;
    localparam int DEF_MAX_ELEMENTS = 16;

    localparam logic [CNT_W-1:0] NUM_ELEMENTS_RESET = CNT_W'(16);

    // Command codes carried in a request beat
    localparam logic [1:0] CMD_ADVANCE = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // Direction of travel held for each value
    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    // Request beat
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ELEM_W-1:0] read_index;
    } sjt_req_t;

    // Response beat
    typedef struct packed {
        logic              advanced;
        logic              finished;
        logic [ELEM_W-1:0] swap_position;
        logic [ELEM_W-1:0] element_at_index;
        logic [ARR_W-1:0]  arrangement;
    } sjt_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic restart;
        logic scan_load;
        logic scan_step;
        logic fetch;
        logic swap_a;
        logic swap_b;
        logic settle;
        logic rsp_load;
        logic advanced;
        logic finished;
    } sjt_op_t;

    // Datapath to controller status
    typedef struct packed {
        logic movable;
        logic scan_last;
    } sjt_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/sjt_datapath.sv */
// Datapath: arrangement, value positions, directions, scan counter and response register.
// Depends on sjt_pkg; driven by sjt_ctrl through sjt_op_t.
`default_nettype none

module sjt_datapath #(
    parameter int MAX_ELEMENTS = sjt_pkg::DEF_MAX_ELEMENTS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [sjt_pkg::CNT_W-1:0]           cfg_data,
    input  wire  [sjt_pkg::ELEM_W-1:0]          read_index,
    input  sjt_pkg::sjt_op_t                    op,
    output sjt_pkg::sjt_stat_t                  stat,
    output sjt_pkg::sjt_rsp_t                   rsp
);
    import sjt_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

    // State stores
    logic [IDX_W-1:0] arr_reg [MAX_ELEMENTS];
    logic [IDX_W-1:0] pos_reg [MAX_ELEMENTS];
    dir_t             dir_reg [MAX_ELEMENTS];
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] numel_reg;

    // Working registers for one advance
    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  mv_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  tgt_reg;
    logic              right_reg;
    logic [IDX_W-1:0]  w_reg;
    logic [ELEM_W-1:0] ri_reg;
    sjt_rsp_t          rsp_reg;

    logic [CNT_W-1:0]  clamp_n;
    dir_t              scan_dir;
    logic [IDX_W-1:0]  scan_pos;
    logic              movable;
    logic [IDX_W-1:0]  nxt;
    logic [IDX_W-1:0]  arr_raddr;
    logic [IDX_W-1:0]  arr_rd;
    logic              stop;
    logic              ri_in_range;
    logic [ARR_W-1:0]  packed_arr;

    // Clamp the configured count into the supported range
    always_comb
    begin
        if (numel_reg == '0)
            clamp_n = CNT_W'(1);
        else if (numel_reg > MAX_CNT)
            clamp_n = MAX_CNT;
        else
            clamp_n = numel_reg;
    end

    // Mobility test of the value under the scan counter
    assign scan_dir = dir_reg[scan_reg];
    assign scan_pos = pos_reg[scan_reg];

    always_comb
    begin
        unique case (scan_dir)
            DIR_LEFT:  movable = (scan_pos != '0) && (CNT_W'(scan_pos) < n_reg);
            DIR_RIGHT: movable = (CNT_W'(scan_pos) + CNT_W'(1)) < n_reg;
            default:   movable = 1'b0;
        endcase
    end

    assign stat.movable   = movable;
    assign stat.scan_last = (scan_reg == '0);

    // Single arrangement read port: target on fetch, next-beyond on settle, else read index
    assign nxt = right_reg ? (tgt_reg + IDX_W'(1)) : (tgt_reg - IDX_W'(1));

    always_comb
    begin
        priority if (op.fetch)
            arr_raddr = tgt_reg;
        else if (op.settle)
            arr_raddr = nxt;
        else
            arr_raddr = ri_reg[IDX_W-1:0];
    end

    assign arr_rd = arr_reg[arr_raddr];

    // Moved value halts at an end or when a larger element lies beyond it
    assign stop = (tgt_reg == '0) || (CNT_W'(tgt_reg) == (n_reg - CNT_W'(1)))
                  || (arr_rd > mv_reg);

    assign ri_in_range = CNT_W'(ri_reg) < MAX_CNT;

    // Pack the arrangement, zero above the store depth
    for (genvar p = 0; p < ARR_W / ELEM_W; p++)
    begin : g_pack
        if (p < MAX_ELEMENTS)
        begin : g_used
            assign packed_arr[p*ELEM_W +: ELEM_W] = ELEM_W'(arr_reg[p]);
        end
        else
        begin : g_unused
            assign packed_arr[p*ELEM_W +: ELEM_W] = '0;
        end
    end

    // Stores and active count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ELEMENTS; i++)
            begin
                arr_reg[i] <= IDX_W'(i);
                pos_reg[i] <= IDX_W'(i);
                dir_reg[i] <= (i != 0) ? DIR_LEFT : DIR_NONE;
            end
            n_reg     <= MAX_CNT;
            numel_reg <= NUM_ELEMENTS_RESET;
        end
        else
        begin
            if (cfg_we)
                numel_reg <= cfg_data;

            // Load the identity arrangement
            if (op.restart)
            begin
                n_reg <= clamp_n;
                for (int i = 0; i < MAX_ELEMENTS; i++)
                begin
                    arr_reg[i] <= IDX_W'(i);
                    pos_reg[i] <= IDX_W'(i);
                    dir_reg[i] <= (i != 0 && CNT_W'(i) < clamp_n) ? DIR_LEFT : DIR_NONE;
                end
            end

            // Drop the displaced value into the mover's old place
            if (op.swap_a)
            begin
                arr_reg[cur_reg] <= w_reg;
                pos_reg[w_reg]   <= cur_reg;
            end

            // Put the mover into its new place
            if (op.swap_b)
            begin
                arr_reg[tgt_reg] <= mv_reg;
                pos_reg[mv_reg]  <= tgt_reg;
            end

            // Halt the mover if needed and turn every larger value towards it
            if (op.settle)
            begin
                for (int i = 0; i < MAX_ELEMENTS; i++)
                begin
                    if (IDX_W'(i) == mv_reg)
                    begin
                        if (stop)
                            dir_reg[i] <= DIR_NONE;
                    end
                    else if (IDX_W'(i) > mv_reg && CNT_W'(i) < n_reg)
                    begin
                        dir_reg[i] <= (pos_reg[i] > tgt_reg) ? DIR_LEFT : DIR_RIGHT;
                    end
                end
            end
        end
    end

    // Scan, move bookkeeping and response payload
    always_ff @(posedge clk)
    begin
        if (op.accept)
            ri_reg <= read_index;

        if (op.scan_load)
            scan_reg <= IDX_W'(n_reg - CNT_W'(1));
        else if (op.scan_step)
        begin
            if (movable)
            begin
                mv_reg    <= scan_reg;
                cur_reg   <= scan_pos;
                right_reg <= (scan_dir == DIR_RIGHT);
                tgt_reg   <= (scan_dir == DIR_RIGHT) ? (scan_pos + IDX_W'(1))
                                                     : (scan_pos - IDX_W'(1));
            end
            else
                scan_reg <= scan_reg - IDX_W'(1);
        end

        if (op.fetch)
            w_reg <= arr_rd;

        if (op.rsp_load)
        begin
            rsp_reg.advanced         <= op.advanced;
            rsp_reg.finished         <= op.finished;
            rsp_reg.swap_position    <= op.advanced
                                        ? ELEM_W'(right_reg ? cur_reg : tgt_reg) : '0;
            rsp_reg.element_at_index <= ri_in_range ? ELEM_W'(arr_rd) : '0;
            rsp_reg.arrangement      <= packed_arr;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

/* hw/rtl/sjt_ctrl.sv */
// Controller state machine: request/response handshakes and sequencing of an advance.
// Depends on sjt_pkg; commands sjt_datapath through sjt_op_t.
`default_nettype none

module sjt_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  wire  [1:0]           req_cmd,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    input  sjt_pkg::sjt_stat_t   stat,
    output sjt_pkg::sjt_op_t     op
);
    import sjt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_SWAP_A,
        S_SWAP_B,
        S_SETTLE,
        S_REPORT
    } state_t;

    state_t state_reg;
    logic   adv_reg;
    logic   fin_reg;
    logic   rsp_valid_reg;
    logic   rsp_free;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Decode datapath commands from the state
    always_comb
    begin
        op          = '0;
        op.advanced = adv_reg;
        op.finished = fin_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op.accept    = 1'b1;
                    op.restart   = (req_cmd == CMD_RESTART);
                    op.scan_load = (req_cmd == CMD_ADVANCE);
                end
            end
            S_SCAN:   op.scan_step = 1'b1;
            S_FETCH:  op.fetch     = 1'b1;
            S_SWAP_A: op.swap_a    = 1'b1;
            S_SWAP_B: op.swap_b    = 1'b1;
            S_SETTLE: op.settle    = 1'b1;
            S_REPORT: op.rsp_load  = rsp_free;
            default:  op           = '0;
        endcase
    end

    // State, result flags and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            adv_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (op.rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        adv_reg   <= 1'b0;
                        fin_reg   <= 1'b0;
                        state_reg <= (req_cmd == CMD_ADVANCE) ? S_SCAN : S_REPORT;
                    end
                end
                S_SCAN:
                begin
                    priority if (stat.movable)
                    begin
                        adv_reg   <= 1'b1;
                        state_reg <= S_FETCH;
                    end
                    else if (stat.scan_last)
                    begin
                        fin_reg   <= 1'b1;
                        state_reg <= S_REPORT;
                    end
                end
                S_FETCH:  state_reg <= S_SWAP_A;
                S_SWAP_A: state_reg <= S_SWAP_B;
                S_SWAP_B: state_reg <= S_SETTLE;
                S_SETTLE: state_reg <= S_REPORT;
                S_REPORT:
                begin
                    if (rsp_free)
                        state_reg <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sjt_permutation_generator.sv */
// Top level of the permutation generator: controller plus datapath.
// Depends on sjt_pkg, sjt_ctrl and sjt_datapath.
//
// Steps through the permutations of 0..n-1 in plain-changes order, one adjacent
// swap per advance request, and returns on every request the element at
// read_index plus the whole arrangement. One request is worked at a time.
// Restart and read-only requests go from acceptance straight to the report
// state, which loads the response register. An advance runs the mobility scan,
// which visits k values, largest first, one value per cycle through the
// position and direction stores (k = n - m for mover m, at most n), then goes
// through the fetch, swap A, swap B and settle states to the report state;
// one that finds nothing to move scans all n values and goes straight to the
// report state. The next request can be taken in the cycle after the load.
// The load waits while the previous response is still held and not being
// taken. A response waiting to be taken does not block acceptance of the next
// request. num_elements is picked up at the next restart; 0 counts as 1 and
// values above MAX_ELEMENTS count as MAX_ELEMENTS. After reset the state is
// as after a restart with n of MAX_ELEMENTS, with num_elements at 16.
`default_nettype none

module sjt_permutation_generator #(
    parameter int MAX_ELEMENTS = sjt_pkg::DEF_MAX_ELEMENTS
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         req_valid,
    output logic                        req_ready,
    input  sjt_pkg::sjt_req_t           req,
    output logic                        rsp_valid,
    input  wire                         rsp_ready,
    output sjt_pkg::sjt_rsp_t           rsp,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [sjt_pkg::CNT_W-1:0]   cfg_data
);
    import sjt_pkg::*;

    sjt_op_t   op;
    sjt_stat_t stat;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    sjt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_cmd   (req.cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .op        (op)
    );

    sjt_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .read_index (req.read_index),
        .op         (op),
        .stat       (stat),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

/* tb/sv/sjt_permutation_generator_test.sv */
// Self-checking testbench for sjt_permutation_generator: directed and random command traffic.
// Depends on sjt_pkg and the sjt_permutation_generator RTL; no other files.
module sjt_permutation_generator_test;
    import sjt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ELEMS     = DEF_MAX_ELEMENTS;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_OFF      = 4;
    localparam int REPORT_CAP    = 40;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    sjt_req_t             req;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    sjt_rsp_t             rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data;

    // Shadow of the generator state
    logic [ELEM_W-1:0]    perm_at [16];
    logic [ELEM_W-1:0]    where_is[16];
    dir_t                 heading [16];
    int                   live_n;
    logic [CNT_W-1:0]     count_reg;

    sjt_rsp_t             awaited_responses[$];

    int send_idle_pct = 27;
    int recv_idle_pct = 76;
    int error_count   = 0;
    int beats_sent    = 0;
    int beats_checked = 0;
    int exhausted     = 0;
    int count_writes  = 0;
    int stall_cycles  = 0;

    sjt_permutation_generator #(
        .MAX_ELEMENTS (MAX_ELEMS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Load the identity arrangement with the clamped element count
    function automatic void load_identity();
        if (count_reg == '0)
            live_n = 1;
        else if (int'(count_reg) > MAX_ELEMS)
            live_n = MAX_ELEMS;
        else
            live_n = int'(count_reg);
        for (int i = 0; i < 16; i++)
        begin
            perm_at[i]  = ELEM_W'(i);
            where_is[i] = ELEM_W'(i);
            heading[i]  = (i != 0 && i < live_n) ? DIR_LEFT : DIR_NONE;
        end
    endfunction

    // Apply one command to the shadow state and return the response it produces
    function automatic sjt_rsp_t apply_command(logic [1:0] c, logic [ELEM_W-1:0] ri);
        sjt_rsp_t          r;
        int                mover;
        int                cur;
        int                tgt;
        int                nxt;
        int                p;
        bit                found;
        logic [ELEM_W-1:0] other;
        r = '0;
        if (c == CMD_ADVANCE)
        begin
            found = 1'b0;
            mover = 0;
            // Find the largest value that can still move
            for (int v = live_n - 1; v >= 0; v--)
            begin
                p = int'(where_is[v]);
                if (!found && ((heading[v] == DIR_LEFT && p >= 1 && p < live_n) ||
                               (heading[v] == DIR_RIGHT && p + 1 < live_n)))
                begin
                    mover = v;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                cur = int'(where_is[mover]);
                tgt = ((heading[mover] == DIR_RIGHT) ? cur + 1 : cur - 1) & 15;
                // Swap the mover with its neighbour
                other           = perm_at[tgt];
                perm_at[cur]    = other;
                where_is[other] = ELEM_W'(cur);
                perm_at[tgt]    = ELEM_W'(mover);
                where_is[mover] = ELEM_W'(tgt);
                // Stop the mover at an end or in front of a larger value
                if (tgt == 0 || tgt == live_n - 1)
                    heading[mover] = DIR_NONE;
                else
                begin
                    nxt = ((heading[mover] == DIR_RIGHT) ? tgt + 1 : tgt - 1) & 15;
                    if (int'(perm_at[nxt]) > mover)
                        heading[mover] = DIR_NONE;
                end
                // Turn every larger value toward the mover
                for (int i = mover + 1; i < live_n; i++)
                    heading[i] = (int'(where_is[i]) > tgt) ? DIR_LEFT : DIR_RIGHT;
                r.advanced      = 1'b1;
                r.swap_position = ELEM_W'((cur < tgt) ? cur : tgt);
            end
            else
                r.finished = 1'b1;
        end
        else if (c == CMD_RESTART)
            load_identity();
        r.element_at_index = (int'(ri) < MAX_ELEMS) ? perm_at[ri] : '0;
        for (int q = 0; q < 16; q++)
            r.arrangement[4*q +: 4] = (q < MAX_ELEMS) ? perm_at[q] : '0;
        return r;
    endfunction

    // Send one request beat, idling first at the current rate
    task automatic send_request(input logic [1:0] c, input logic [ELEM_W-1:0] ri);
        sjt_rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            req       <= sjt_req_t'($urandom);
            @(negedge clk);
        end
        req_valid      <= 1'b1;
        req.cmd        <= c;
        req.read_index <= ri;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_command(c, ri);
        if (predicted.finished)
            exhausted++;
        awaited_responses.push_back(predicted);
        beats_sent++;
    endtask

    // Drop the request, let the block drain, then write the element count
    task automatic write_count(input logic [CNT_W-1:0] value);
        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        count_reg = value;
        count_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Drive the receiver's ready at the current stall rate
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each response beat with the oldest prediction
    always @(posedge clk)
    begin
        sjt_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_CAP)
                    $display("%0t ns: response beat with none pending, actual %h", $time, rsp);
            end
            else
            begin
                want = awaited_responses.pop_front();
                check_field("advanced", 64'(want.advanced), 64'(rsp.advanced));
                check_field("finished", 64'(want.finished), 64'(rsp.finished));
                check_field("swap_position", 64'(want.swap_position), 64'(rsp.swap_position));
                check_field("element_at_index", 64'(want.element_at_index),
                            64'(rsp.element_at_index));
                check_field("arrangement", want.arrangement, rsp.arrangement);
                beats_checked++;
            end
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Reset state: reads at both ends, unused code, advance with the reset count
    task automatic test_reset_state();
        send_request(CMD_READ, 4'd0);
        send_request(CMD_READ, 4'd15);
        send_request(CMD_UNUSED, 4'd7);
        send_request(CMD_ADVANCE, 4'd15);
        send_request(CMD_ADVANCE, 4'd14);
        send_request(CMD_RESTART, 4'd3);
    endtask

    // A count write waits for the next restart; then exhaust three elements
    task automatic test_deferred_count();
        write_count(5'd3);
        send_request(CMD_ADVANCE, 4'd1);
        send_request(CMD_RESTART, 4'd2);
        for (int i = 0; i < 7; i++)
            send_request(CMD_ADVANCE, ELEM_W'(i));
    endtask

    // Out-of-range counts clamp to one and to the maximum
    task automatic test_count_clamp();
        write_count(5'd0);
        send_request(CMD_RESTART, 4'd0);
        send_request(CMD_ADVANCE, 4'd0);
        send_request(CMD_READ, 4'd9);
        write_count(5'd17);
        send_request(CMD_RESTART, 4'd15);
        send_request(CMD_ADVANCE, 4'd15);
        write_count(5'd31);
        send_request(CMD_RESTART, 4'd8);
        send_request(CMD_ADVANCE, 4'd14);
    endtask

    // Random walks: set a count, restart, then mostly advances with some noise
    task automatic test_random_walks(input int send_pct, input int recv_pct, input int quota);
        int               start;
        int               steps;
        int               roll;
        int               n_eff;
        logic [CNT_W-1:0] n_req;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = beats_sent;
        while (beats_sent - start < quota)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                n_req = CNT_W'($urandom_range(2, 5));
            else if (roll < 60)
                n_req = CNT_W'($urandom_range(6, 16));
            else if (roll < 70)
                n_req = CNT_W'($urandom_range(0, 1));
            else if (roll < 80)
                n_req = CNT_W'($urandom_range(17, 31));
            else
                n_req = CNT_W'($urandom_range(0, 31));
            write_count(n_req);
            send_request(CMD_RESTART, ELEM_W'($urandom_range(0, 15)));
            n_eff = live_n;
            if (n_eff <= 5)
            begin
                steps = 1;
                for (int k = 2; k <= n_eff; k++)
                    steps = steps * k;
                steps = steps + $urandom_range(0, 3);
            end
            else
                steps = $urandom_range(10, 60);
            for (int s = 0; s < steps; s++)
            begin
                roll = $urandom_range(99);
                if (roll < 80)
                    send_request(CMD_ADVANCE, ELEM_W'($urandom_range(0, 15)));
                else if (roll < 90)
                    send_request((roll < 85) ? CMD_READ : CMD_UNUSED,
                                 ELEM_W'($urandom_range(0, 15)));
                else if (roll < 95)
                    send_request(CMD_RESTART, ELEM_W'($urandom_range(0, 15)));
                else
                    send_request(2'($urandom_range(0, 3)), ELEM_W'($urandom_range(0, 15)));
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        count_reg = NUM_ELEMENTS_RESET;
        load_identity();

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_deferred_count();
        test_count_clamp();
        test_random_walks(27, 76, 430);
        test_random_walks(76, 27, 430);
        test_random_walks(0, 0, 430);

        // Drain the remaining responses, then let the block settle
        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_responses.size() != 0)
        begin
            error_count++;
            $display("%0t ns: %0d responses never arrived", $time, awaited_responses.size());
        end

        $display("Sent %0d commands over %0d count writes; checked %0d responses,",
                 beats_sent, count_writes, beats_checked);
        $display("%0d of them exhausted advances; %0d field mismatches.",
                 exhausted, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/sjt_pkg.sv
hw/rtl/sjt_datapath.sv
hw/rtl/sjt_ctrl.sv
hw/rtl/sjt_permutation_generator.sv
tb/sv/sjt_permutation_generator_test.sv
